[hdl/dglht_pkg.sv]
// Package: shared constants and types for the dual ghost LRU hit tracker.
package dglht_pkg;
  localparam int GhostEntriesDef = 64;
  localparam int KeyBitsDef      = 32;
  localparam int InKeyW          = 32;
  localparam int HitW            = 32;
  localparam int ShareW          = 16;

  localparam logic [1:0] FUNC_DEMOTE_INS = 2'd0;
  localparam logic [1:0] FUNC_READ_INS   = 2'd1;
  localparam logic [1:0] FUNC_PROBE      = 2'd2;
  localparam logic [1:0] FUNC_STAT_RST   = 2'd3;

  localparam logic [HitW-1:0] HIT_ONE = 32'd1;
  localparam logic [HitW-1:0] HIT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic            demote_hit;
    logic            read_hit;
    logic [HitW-1:0] demote_hit_count;
    logic [HitW-1:0] read_hit_count;
    logic [ShareW-1:0] demote_share;
    logic [ShareW-1:0] read_share;
  } dglht_res_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [InKeyW-1:0] block_key;
  } dglht_cmd_t;
endpackage

[hdl/dglht_if.sv]
// Interfaces: valid/ready channels for command and result words.
interface dglht_in_if import dglht_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [InKeyW-1:0] block_key;
  modport source (output valid, func, block_key, input ready);
  modport sink   (input valid, func, block_key, output ready);
endinterface

interface dglht_out_if import dglht_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              demote_hit;
  logic              read_hit;
  logic [HitW-1:0]   demote_hit_count;
  logic [HitW-1:0]   read_hit_count;
  logic [ShareW-1:0] demote_share;
  logic [ShareW-1:0] read_share;
  modport source (output valid, demote_hit, read_hit, demote_hit_count, read_hit_count,
                  demote_share, read_share, input ready);
  modport sink   (input valid, demote_hit, read_hit, demote_hit_count, read_hit_count,
                  demote_share, read_share, output ready);
endinterface

[hdl/dglht_cmd_fifo.sv]
// Two-entry command queue between the front and the back.
module dglht_cmd_fifo import dglht_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  dglht_cmd_t wr_data,
  output logic       rd_valid,
  input  logic       rd_ready,
  output dglht_cmd_t rd_data
);
  dglht_cmd_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule

[hdl/dglht_list.sv]
// One ghost LRU list: key and rank memories with a slot scan sequencer.
module dglht_list import dglht_pkg::*; #(
  parameter int GHOST_ENTRIES = GhostEntriesDef,
  parameter int KEY_BITS      = KeyBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,     // pulse: begin an operation
  input  logic                is_insert, // 1 insert, 0 probe
  input  logic [KEY_BITS-1:0] key,
  output logic                idle,
  output logic                done,      // pulse
  output logic                hit
);
  localparam int IW = (GHOST_ENTRIES > 1) ? $clog2(GHOST_ENTRIES) : 1;
  localparam int RW = $clog2(GHOST_ENTRIES + 1);
  localparam logic [IW-1:0] LAST = IW'(GHOST_ENTRIES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_TOUCH = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;
  localparam logic [2:0] S_CLR   = 3'd5;

  logic [KEY_BITS-1:0] keys_mem [GHOST_ENTRIES];
  logic [RW-1:0]       rank_mem [GHOST_ENTRIES];
  logic [RW-1:0]       count_r;

  logic [2:0]          state_r;
  logic [IW-1:0]       idx_r;
  logic [IW-1:0]       slot_r;
  logic                found_r, first_last_r;
  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] rd_key_r;
  logic [RW-1:0]       rd_rank_r;
  logic [RW-1:0]       touch_rank_r;
  logic [IW-1:0]       rd_idx_r;
  logic                rd_last_r;
  logic                is_ins_r;
  logic [IW-1:0]       empty_slot_r, oldest_slot_r;
  logic                have_empty_r;

  // Memories: one registered read per cycle at idx_r, one write per cycle.
  logic          key_we;
  logic [IW-1:0] mem_wa;
  logic          rank_we;
  logic [IW-1:0] rank_wa;
  logic [RW-1:0] rank_wd;
  always_ff @(posedge clk) begin
    rd_key_r  <= keys_mem[idx_r];
    rd_rank_r <= rank_mem[idx_r];
    if (key_we) keys_mem[mem_wa] <= key_r;
    if (rank_we) rank_mem[rank_wa] <= rank_wd;
  end

  always_comb begin
    key_we  = 1'b0;
    mem_wa  = have_empty_r ? empty_slot_r : oldest_slot_r;
    rank_we = 1'b0;
    rank_wa = rd_idx_r;
    rank_wd = '0;
    case (state_r)
      S_CLR: begin
        rank_we = 1'b1;
        rank_wa = idx_r;
      end
      S_CMP: begin
        if (!found_r && is_ins_r) begin
          key_we = 1'b1;
          if (have_empty_r) begin
            rank_we = 1'b1;
            rank_wa = empty_slot_r;
            rank_wd = count_r + RW'(1);
          end
        end
      end
      S_TOUCH: begin
        // second pass: touched slot becomes newest, younger ranks close the gap
        if (first_last_r) begin
          if (rd_idx_r == slot_r) begin
            rank_we = 1'b1;
            rank_wd = count_r;
          end else if (rd_rank_r > touch_rank_r) begin
            rank_we = 1'b1;
            rank_wd = rd_rank_r - RW'(1);
          end
        end
      end
      default: rank_wd = '0;
    endcase
  end

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE);
  assign hit  = found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      count_r      <= '0;
      found_r      <= 1'b0;
      idx_r        <= '0;
      rd_last_r    <= 1'b0;
      first_last_r <= 1'b0;
    end else begin
      case (state_r)
        S_CLR: begin
          // empty every slot once after reset
          if (idx_r == LAST) begin
            idx_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            state_r      <= S_SCAN;
            idx_r        <= '0;
            found_r      <= 1'b0;
            have_empty_r <= 1'b0;
            is_ins_r     <= is_insert;
            key_r        <= key;
            rd_last_r    <= 1'b0;
            first_last_r <= 1'b0;
          end
        end
        S_SCAN: begin
          // pipeline: rd_key_r/rd_rank_r hold slot rd_idx_r once first_last_r set
          if (first_last_r) begin
            if (rd_rank_r != '0 && rd_key_r == key_r && !found_r) begin
              found_r      <= 1'b1;
              slot_r       <= rd_idx_r;
              touch_rank_r <= rd_rank_r;
            end
            if (rd_rank_r == '0 && !have_empty_r) begin
              have_empty_r <= 1'b1;
              empty_slot_r <= rd_idx_r;
            end
            if (rd_rank_r == RW'(1)) oldest_slot_r <= rd_idx_r;
            if (rd_last_r) state_r <= S_CMP;
          end
          first_last_r <= 1'b1;
          rd_idx_r     <= idx_r;
          rd_last_r    <= (idx_r == LAST);
          if (idx_r != LAST) idx_r <= idx_r + IW'(1);
        end
        S_CMP: begin
          idx_r        <= '0;
          first_last_r <= 1'b0;
          rd_last_r    <= 1'b0;
          if (found_r) begin
            state_r <= S_TOUCH;
          end else if (is_ins_r) begin
            if (have_empty_r) begin
              count_r <= count_r + RW'(1);
              state_r <= S_DONE;
            end else begin
              slot_r       <= oldest_slot_r;
              touch_rank_r <= RW'(1);
              state_r      <= S_TOUCH;
            end
          end else begin
            state_r <= S_DONE;
          end
        end
        S_TOUCH: begin
          if (first_last_r && rd_last_r) state_r <= S_DONE;
          first_last_r <= 1'b1;
          rd_idx_r     <= idx_r;
          rd_last_r    <= (idx_r == LAST);
          if (idx_r != LAST) idx_r <= idx_r + IW'(1);
        end
        S_DONE: begin
          state_r <= S_IDLE;
          if (is_ins_r) found_r <= 1'b0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[hdl/dglht_divider.sv]
// Restoring divider: (part << 16) / sum, one quotient bit per cycle.
module dglht_divider import dglht_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [HitW-1:0]   part,
  input  logic [HitW:0]     sum,
  output logic              done,
  output logic [ShareW-1:0] quot
);
  localparam int NB = HitW + ShareW;
  localparam int CW = $clog2(NB + 1);
  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [NB-1:0] num_r;
  logic [HitW+1:0] rem_r;
  logic [NB-1:0] q_r;
  logic [HitW+1:0] trial;

  assign trial = {rem_r[HitW:0], num_r[NB-1]};
  assign done  = done_r;
  // sum exceeds part, so quotient fits in 16 bits
  assign quot  = q_r[ShareW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NB);
        num_r  <= {part, {ShareW{1'b0}}};
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        num_r <= num_r << 1;
        if (trial >= {1'b0, sum}) begin
          rem_r <= trial - {1'b0, sum};
          q_r   <= {q_r[NB-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[NB-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

[hdl/dglht_back.sv]
// Back end: runs list operations, updates counters, computes shares.
module dglht_back import dglht_pkg::*; #(
  parameter int GHOST_ENTRIES = GhostEntriesDef,
  parameter int KEY_BITS      = KeyBitsDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  dglht_cmd_t cmd,
  output logic       res_valid,
  input  logic       res_ready,
  output dglht_res_t res
);
  // compared key bits: the low KEY_BITS of the input key, at most all of it
  localparam int KW = (KEY_BITS < InKeyW) ? KEY_BITS : InKeyW;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_LIST = 3'd1;
  localparam logic [2:0] B_DIV  = 3'd2;
  localparam logic [2:0] B_WAIT = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [2:0]          state_r;
  logic [1:0]          func_r;
  logic [HitW-1:0]     dh_r, rh_r;
  logic [ShareW-1:0]   dsh_r, rsh_r;
  logic                dflag_r, rflag_r, dseen_r, rseen_r, dq_r, rq_r;
  logic                res_valid_r;
  dglht_res_t          res_r;

  logic d_start, r_start, d_done, r_done, d_hit, r_hit, d_idle, r_idle;
  logic dv_start, dv_done_d, dv_done_r;
  logic [ShareW-1:0] qd, qr;
  logic [HitW:0] sum;

  assign sum = {1'b0, dh_r} + {1'b0, rh_r};

  assign d_start = cmd_valid && cmd_ready &&
                   (cmd.func == FUNC_DEMOTE_INS || cmd.func == FUNC_PROBE);
  assign r_start = cmd_valid && cmd_ready &&
                   (cmd.func == FUNC_READ_INS || cmd.func == FUNC_PROBE);
  assign dv_start = (state_r == B_DIV);

  dglht_list #(.GHOST_ENTRIES(GHOST_ENTRIES), .KEY_BITS(KW)) u_dlist (
    .clk, .rst_n, .start(d_start), .is_insert(cmd.func == FUNC_DEMOTE_INS),
    .key(cmd.block_key[KW-1:0]), .idle(d_idle), .done(d_done), .hit(d_hit));
  dglht_list #(.GHOST_ENTRIES(GHOST_ENTRIES), .KEY_BITS(KW)) u_rlist (
    .clk, .rst_n, .start(r_start), .is_insert(cmd.func == FUNC_READ_INS),
    .key(cmd.block_key[KW-1:0]), .idle(r_idle), .done(r_done), .hit(r_hit));
  dglht_divider u_ddiv (.clk, .rst_n, .start(dv_start), .part(dh_r), .sum,
                        .done(dv_done_d), .quot(qd));
  dglht_divider u_rdiv (.clk, .rst_n, .start(dv_start), .part(rh_r), .sum,
                        .done(dv_done_r), .quot(qr));

  assign cmd_ready = (state_r == B_IDLE) && !res_valid_r && d_idle && r_idle;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      res_valid_r <= 1'b0;
      dh_r        <= HIT_ONE;
      rh_r        <= HIT_ONE;
      dsh_r       <= '0;
      rsh_r       <= '0;
    end else begin
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            func_r  <= cmd.func;
            dq_r    <= d_start;
            rq_r    <= r_start;
            dseen_r <= 1'b0;
            rseen_r <= 1'b0;
            dflag_r <= 1'b0;
            rflag_r <= 1'b0;
            if (cmd.func == FUNC_STAT_RST) begin
              dh_r    <= HIT_ONE;
              rh_r    <= HIT_ONE;
              dsh_r   <= '0;
              rsh_r   <= '0;
              state_r <= B_OUT;
            end else begin
              state_r <= B_LIST;
            end
          end
        end
        B_LIST: begin
          if (d_done) begin
            dseen_r <= 1'b1;
            if (func_r == FUNC_PROBE && d_hit) begin
              dflag_r <= 1'b1;
              if (dh_r != HIT_MAX) dh_r <= dh_r + HIT_ONE;
            end
          end
          if (r_done) begin
            rseen_r <= 1'b1;
            if (func_r == FUNC_PROBE && r_hit) begin
              rflag_r <= 1'b1;
              if (rh_r != HIT_MAX) rh_r <= rh_r + HIT_ONE;
            end
          end
          if ((dseen_r || d_done || !dq_r) && (rseen_r || r_done || !rq_r)) begin
            state_r <= (func_r == FUNC_PROBE) ? B_DIV : B_OUT;
          end
        end
        B_DIV: state_r <= B_WAIT;
        B_WAIT: begin
          if (dv_done_d && dv_done_r) begin
            dsh_r   <= qd;
            rsh_r   <= qr;
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          res_r.demote_hit       <= dflag_r;
          res_r.read_hit         <= rflag_r;
          res_r.demote_hit_count <= dh_r;
          res_r.read_hit_count   <= rh_r;
          res_r.demote_share     <= dsh_r;
          res_r.read_share       <= rsh_r;
          res_valid_r            <= 1'b1;
          state_r                <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end
endmodule

[hdl/dual_ghost_lru_hit_tracker_core.sv]
// Top level: dual ghost LRU hit tracker, queue-decoupled front and back.
//
//  channel | dir | fields                                    | handshake
//  in_     | in  | func, block_key                           | valid/ready
//  out_    | out | demote_hit, read_hit, *_hit_count, *_share| valid/ready
//
// Each list operation scans all GHOST_ENTRIES slots through single-port reads;
// an insert that moves or evicts an entry takes a second pass that renumbers
// the ranks. A probe adds the 48-bit serial share division. One word is
// worked at a time. Reset (rst_n low, synchronous) sets counters to 1;
// afterwards a clearing pass empties both lists before the first word.
// The front queue holds two words; a stalled result register blocks the back
// only, the queue keeps taking words until full.
module dual_ghost_lru_hit_tracker_core import dglht_pkg::*; #(
  parameter int GHOST_ENTRIES = GhostEntriesDef,
  parameter int KEY_BITS      = KeyBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  dglht_in_if.sink    in_ch,
  dglht_out_if.source out_ch
);
  dglht_cmd_t in_word, q_word;
  dglht_res_t res;
  logic       q_valid, q_ready;

  // key bits above KEY_BITS are ignored
  assign in_word.func      = in_ch.func;
  assign in_word.block_key = in_ch.block_key;

  dglht_cmd_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(in_ch.valid), .wr_ready(in_ch.ready), .wr_data(in_word),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_word));

  dglht_back #(.GHOST_ENTRIES(GHOST_ENTRIES), .KEY_BITS(KEY_BITS)) u_back (
    .clk, .rst_n,
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_word),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res);

  assign out_ch.demote_hit       = res.demote_hit;
  assign out_ch.read_hit         = res.read_hit;
  assign out_ch.demote_hit_count = res.demote_hit_count;
  assign out_ch.read_hit_count   = res.read_hit_count;
  assign out_ch.demote_share     = res.demote_share;
  assign out_ch.read_share       = res.read_share;
endmodule

[tb/dglht_tb_if.sv]
`timescale 1ns / 1ps
// Testbench-side note: interfaces come from the RTL; this file holds the word-level helpers.
package dglht_tb_pkg;
  import dglht_pkg::*;

  // One expected result word.
  typedef struct {
    logic              demote_hit;
    logic              read_hit;
    logic [HitW-1:0]   demote_hit_count;
    logic [HitW-1:0]   read_hit_count;
    logic [ShareW-1:0] demote_share;
    logic [ShareW-1:0] read_share;
  } tracker_word_t;
endpackage

[tb/dual_ghost_lru_hit_tracker_core_tb.sv]
`timescale 1ns / 1ps
// Testbench top: drives command words into the tracker and checks every result word.
module dual_ghost_lru_hit_tracker_core_tb;
  import dglht_pkg::*;
  import dglht_tb_pkg::*;

  localparam int NSLOT = GhostEntriesDef;
  localparam int NDIR  = 21;
  localparam int NRAND = 1650;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  dglht_in_if  in_ch ();
  dglht_out_if out_ch ();

  dual_ghost_lru_hit_tracker_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Shadow copy of both ghost lists and the statistics.
  logic [31:0] dem_keys [NSLOT];
  int unsigned dem_rank [NSLOT];
  logic [31:0] rd_keys  [NSLOT];
  int unsigned rd_rank  [NSLOT];
  logic [HitW-1:0]   dem_hits, rd_hits;
  logic [ShareW-1:0] dem_frac, rd_frac;

  tracker_word_t expected_q [$];
  int mismatches = 0;
  int phase = 0;       // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  logic use_fixed;     // directed row carries a typed-in word
  tracker_word_t fixed_word;

  // Directed rows: func, key, typed expectation where obvious.
  typedef struct {
    logic [1:0]  func;
    logic [31:0] key;
    logic        fixed;
    tracker_word_t w;
  } dir_row_t;
  dir_row_t dir_tab [NDIR];

  function automatic int find_slot(ref logic [31:0] k [NSLOT], ref int unsigned r [NSLOT],
                                   input logic [31:0] key);
    for (int i = 0; i < NSLOT; i++)
      if (r[i] != 0 && k[i] == key) return i;
    return -1;
  endfunction

  function automatic void bump_recent(ref int unsigned r [NSLOT], input int s);
    int unsigned old_rank, n;
    old_rank = r[s];
    n = 0;
    for (int i = 0; i < NSLOT; i++) if (r[i] != 0) n++;
    for (int i = 0; i < NSLOT; i++) if (r[i] > old_rank) r[i]--;
    r[s] = n;
  endfunction

  function automatic void ghost_insert(ref logic [31:0] k [NSLOT], ref int unsigned r [NSLOT],
                                       input logic [31:0] key);
    int s, n;
    s = find_slot(k, r, key);
    if (s >= 0) begin
      bump_recent(r, s);
      return;
    end
    n = 0;
    for (int i = 0; i < NSLOT; i++) if (r[i] != 0) n++;
    if (n >= NSLOT) begin
      s = 0;
      for (int i = 0; i < NSLOT; i++) if (r[i] == 1) s = i;
      k[s] = key;
      bump_recent(r, s);
      return;
    end
    for (int i = 0; i < NSLOT; i++)
      if (r[i] == 0) begin
        k[i] = key;
        r[i] = n + 1;
        return;
      end
  endfunction

  function automatic logic [ShareW-1:0] share_q16(logic [HitW-1:0] part, logic [HitW:0] sum);
    logic [HitW+16:0] q;
    q = {part, 16'h0} / sum;
    return (q > 17'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  // Advance the shadow state by one command word and return the result it yields.
  function automatic tracker_word_t track_word(logic [1:0] func, logic [31:0] key);
    tracker_word_t w;
    int s;
    w.demote_hit = 1'b0;
    w.read_hit   = 1'b0;
    case (func)
      FUNC_DEMOTE_INS: ghost_insert(dem_keys, dem_rank, key);
      FUNC_READ_INS:   ghost_insert(rd_keys, rd_rank, key);
      FUNC_PROBE: begin
        s = find_slot(dem_keys, dem_rank, key);
        if (s >= 0) begin
          bump_recent(dem_rank, s);
          if (dem_hits != HIT_MAX) dem_hits++;
          w.demote_hit = 1'b1;
        end
        s = find_slot(rd_keys, rd_rank, key);
        if (s >= 0) begin
          bump_recent(rd_rank, s);
          if (rd_hits != HIT_MAX) rd_hits++;
          w.read_hit = 1'b1;
        end
        dem_frac = share_q16(dem_hits, {1'b0, dem_hits} + {1'b0, rd_hits});
        rd_frac  = share_q16(rd_hits, {1'b0, dem_hits} + {1'b0, rd_hits});
      end
      default: begin
        dem_hits = HIT_ONE;
        rd_hits  = HIT_ONE;
        dem_frac = '0;
        rd_frac  = '0;
      end
    endcase
    w.demote_hit_count = dem_hits;
    w.read_hit_count   = rd_hits;
    w.demote_share     = dem_frac;
    w.read_share       = rd_frac;
    return w;
  endfunction

  function automatic tracker_word_t mk_word(logic dh, logic rh, logic [31:0] dc, logic [31:0] rc,
                                            logic [15:0] ds, logic [15:0] rs);
    tracker_word_t w;
    w.demote_hit = dh; w.read_hit = rh;
    w.demote_hit_count = dc; w.read_hit_count = rc;
    w.demote_share = ds; w.read_share = rs;
    return w;
  endfunction

  function automatic void add_row(int i, logic [1:0] f, logic [31:0] k, logic fx,
                                  tracker_word_t w);
    dir_tab[i].func = f; dir_tab[i].key = k; dir_tab[i].fixed = fx; dir_tab[i].w = w;
  endfunction

  // Result checker: compare every accepted word with the oldest expectation.
  always @(posedge clk) begin
    tracker_word_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
      end else begin
        e = expected_q.pop_front();
        if (out_ch.demote_hit !== e.demote_hit || out_ch.read_hit !== e.read_hit ||
            out_ch.demote_hit_count !== e.demote_hit_count ||
            out_ch.read_hit_count !== e.read_hit_count ||
            out_ch.demote_share !== e.demote_share || out_ch.read_share !== e.read_share) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit %b%b cnt %h %h sh %h %h, got %b%b cnt %h %h sh %h %h",
                     e.demote_hit, e.read_hit, e.demote_hit_count, e.read_hit_count,
                     e.demote_share, e.read_share, out_ch.demote_hit, out_ch.read_hit,
                     out_ch.demote_hit_count, out_ch.read_hit_count,
                     out_ch.demote_share, out_ch.read_share);
        end
      end
    end
  end

  // Receiver back-pressure per phase.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (phase == 2) out_ch.ready <= ($urandom_range(99) >= 82);
    else if (phase == 3) out_ch.ready <= ($urandom_range(99) >= 33);
    else out_ch.ready <= 1'b1;
  end

  // Send one word; holds valid until accepted, idles first per phase.
  task automatic send_word(logic [1:0] f, logic [31:0] k);
    int pct;
    pct = (phase == 1) ? 82 : (phase == 3) ? 33 : 0;
    while (pct != 0 && $urandom_range(99) < pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.block_key <= k;
    if (use_fixed) expected_q.push_back(fixed_word);
    else expected_q.push_back(track_word(f, k));
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Random key: mostly from a small pool so lists hit, fill and evict.
  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 32'h1000 + $urandom_range(90);
    if (r < 80) return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    return $urandom;
  endfunction

  initial begin
    tracker_word_t rst_w;
    logic [1:0] f;
    int r;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_DEMOTE_INS;
    in_ch.block_key = '0;
    use_fixed = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      dem_keys[i] = '0; dem_rank[i] = 0; rd_keys[i] = '0; rd_rank[i] = 0;
    end
    dem_hits = HIT_ONE; rd_hits = HIT_ONE; dem_frac = '0; rd_frac = '0;
    rst_w = mk_word(1'b0, 1'b0, 32'd1, 32'd1, 16'h0, 16'h0);

    // Directed table: miss on empty lists, key extremes, hits on each list and both.
    add_row(0,  FUNC_PROBE,      32'h0,         1'b1,
            mk_word(1'b0, 1'b0, 32'd1, 32'd1, 16'h8000, 16'h8000));
    add_row(1,  FUNC_STAT_RST,   32'h0,         1'b1, rst_w);
    add_row(2,  FUNC_DEMOTE_INS, 32'h0,         1'b1, rst_w);
    add_row(3,  FUNC_READ_INS,   32'hFFFF_FFFF, 1'b1, rst_w);
    add_row(4,  FUNC_PROBE,      32'h0,         1'b1,
            mk_word(1'b1, 1'b0, 32'd2, 32'd1, 16'hAAAA, 16'h5555));
    add_row(5,  FUNC_PROBE,      32'hFFFF_FFFF, 1'b0, rst_w);
    add_row(6,  FUNC_DEMOTE_INS, 32'hFFFF_FFFF, 1'b0, rst_w);
    add_row(7,  FUNC_PROBE,      32'hFFFF_FFFF, 1'b0, rst_w);
    add_row(8,  FUNC_DEMOTE_INS, 32'h0,         1'b0, rst_w);
    add_row(9,  FUNC_READ_INS,   32'h5A5A_A5A5, 1'b0, rst_w);
    add_row(10, FUNC_PROBE,      32'hA5A5_5A5A, 1'b0, rst_w);
    add_row(11, FUNC_PROBE,      32'h5A5A_A5A5, 1'b0, rst_w);
    add_row(12, FUNC_STAT_RST,   32'hFFFF_FFFF, 1'b1, rst_w);
    add_row(13, FUNC_READ_INS,   32'h8000_0000, 1'b0, rst_w);
    add_row(14, FUNC_READ_INS,   32'h0000_0001, 1'b0, rst_w);
    add_row(15, FUNC_READ_INS,   32'h8000_0000, 1'b0, rst_w);
    add_row(16, FUNC_PROBE,      32'h0000_0001, 1'b0, rst_w);
    add_row(17, FUNC_PROBE,      32'h8000_0000, 1'b0, rst_w);
    add_row(18, FUNC_PROBE,      32'h0,         1'b0, rst_w);
    add_row(19, FUNC_STAT_RST,   32'h1234_5678, 1'b1, rst_w);
    add_row(20, FUNC_PROBE,      32'h7FFF_FFFF, 1'b0, rst_w);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NDIR; i++) begin
      use_fixed  = dir_tab[i].fixed;
      fixed_word = dir_tab[i].w;
      send_word(dir_tab[i].func, dir_tab[i].key);
      // Keep the shadow state in step with typed-in rows too.
      if (dir_tab[i].fixed) void'(track_word(dir_tab[i].func, dir_tab[i].key));
    end
    use_fixed = 1'b0;

    // Random part in four idling phases; rare statistics resets.
    for (int i = 0; i < NRAND; i++) begin
      phase = (i * 4) / NRAND;
      r = $urandom_range(99);
      f = (r < 35) ? FUNC_DEMOTE_INS : (r < 70) ? FUNC_READ_INS :
          (r < 98) ? FUNC_PROBE : FUNC_STAT_RST;
      send_word(f, pick_key());
    end
    in_ch.valid <= 1'b0;
    phase = 0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: bounds a run of ~1700 words with heavy stalls, several times over.
  initial begin
    #60_000_000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
